>>> design/wpr_pkg.sv
// ----------------------------------------------------------------------------
// wpr_pkg
// shared types and constants of the partial product reducer
// ----------------------------------------------------------------------------
package wpr_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned PLEN = 64;

    typedef logic [XLEN-1:0] t_opnd;
    typedef logic [PLEN-1:0] t_row;
    typedef logic [1:0]      t_op;

    // operation codes
    localparam t_op OP_SIGNED   = 2'd0;
    localparam t_op OP_NEG_LO   = 2'd1;
    localparam t_op OP_NEG_HI   = 2'd2;
    localparam t_op OP_UNSIGNED = 2'd3;

    // flags that travel with a word down the pipeline
    typedef struct packed {
        logic fill;       // sign-fill the rows
        logic hi_sel;     // high half select
        logic neg;        // product is negative
    } t_flags;

endpackage

>>> design/wpr_in_if.sv
// ----------------------------------------------------------------------------
// wpr_in_if
// input channel: two operands and an operation code
// ----------------------------------------------------------------------------
interface wpr_in_if;
    logic          valid;
    logic          ready;
    wpr_pkg::t_opnd operand_a;
    wpr_pkg::t_opnd operand_b;
    wpr_pkg::t_op   operation;

    modport source (output valid, operand_a, operand_b, operation, input ready);
    modport sink   (input valid, operand_a, operand_b, operation, output ready);
endinterface

>>> design/wpr_out_if.sv
// ----------------------------------------------------------------------------
// wpr_out_if
// output channel: five carry-save rows and two flags
// ----------------------------------------------------------------------------
interface wpr_out_if;
    logic          valid;
    logic          ready;
    wpr_pkg::t_row row_sum_a;
    wpr_pkg::t_row row_carry_a;
    wpr_pkg::t_row row_sum_b;
    wpr_pkg::t_row row_carry_b;
    wpr_pkg::t_row row_leftover;
    logic          high_half_select;
    logic          result_negative;

    modport source (output valid, row_sum_a, row_carry_a, row_sum_b, row_carry_b,
                    row_leftover, high_half_select, result_negative, input ready);
    modport sink   (input valid, row_sum_a, row_carry_a, row_sum_b, row_carry_b,
                    row_leftover, high_half_select, result_negative, output ready);
endinterface

>>> design/wpr_csa3.sv
// ----------------------------------------------------------------------------
// wpr_csa3
// 64-bit 3:2 carry-save adder, carry shifted up one bit
// ----------------------------------------------------------------------------
module wpr_csa3 (
    input  wpr_pkg::t_row i_x,
    input  wpr_pkg::t_row i_y,
    input  wpr_pkg::t_row i_z,
    output wpr_pkg::t_row o_s,
    output wpr_pkg::t_row o_c
);

    wpr_pkg::t_row w_t;
    wpr_pkg::t_row w_maj;

    assign w_t   = i_x ^ i_y;
    assign w_maj = (i_x & i_y) | (w_t & i_z);
    assign o_s   = w_t ^ i_z;
    // carry out of the top bit is dropped
    assign o_c   = {w_maj[wpr_pkg::PLEN-2:0], 1'b0};

endmodule

>>> design/wpr_prep.sv
// ----------------------------------------------------------------------------
// wpr_prep
// operand adjustment by operation code and sign flags
// ----------------------------------------------------------------------------
module wpr_prep (
    input  wpr_pkg::t_opnd  i_a,
    input  wpr_pkg::t_opnd  i_b,
    input  wpr_pkg::t_op    i_op,
    output wpr_pkg::t_opnd  o_a,
    output wpr_pkg::t_opnd  o_b,
    output wpr_pkg::t_flags o_flags
);

    localparam int unsigned MSB = wpr_pkg::XLEN - 1;

    logic w_negate;
    logic w_sgn;

    always_comb begin
        w_negate = ((i_op == wpr_pkg::OP_NEG_LO) || (i_op == wpr_pkg::OP_NEG_HI))
                   && i_a[MSB] && i_b[MSB];
        w_sgn    = (i_op != wpr_pkg::OP_UNSIGNED) && !w_negate;
        // both negative: two's complement of both, then unsigned
        o_a      = w_negate ? (~i_a + wpr_pkg::t_opnd'(1)) : i_a;
        o_b      = w_negate ? (~i_b + wpr_pkg::t_opnd'(1)) : i_b;
        o_flags.fill   = w_sgn && o_a[MSB];
        o_flags.hi_sel = (i_op != wpr_pkg::OP_NEG_LO);
        o_flags.neg    = w_sgn && (o_a[MSB] != o_b[MSB]);
    end

endmodule

>>> design/wallace_partial_product_reducer.sv
// ----------------------------------------------------------------------------
// wallace_partial_product_reducer
// carry-save reduction of the 32 partial products of a 32x32 multiply
// ----------------------------------------------------------------------------
// Takes one word per cycle and gives one result word per cycle while the
// output side does not stall. The work is split into four register stages:
// operand adjustment (the 32-bit negation), row generation with the first
// adder level, adder levels two and three, and levels four and five into
// the output register. Every stage holds its own valid bit and moves on
// whenever the stage after it is empty or moving, so a stalled output holds
// its word while earlier stages keep filling and no word is lost or
// repeated. The five rows still need a final carry-propagate add outside
// this block.
// ----------------------------------------------------------------------------
module wallace_partial_product_reducer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wpr_in_if.sink        i_in,
    wpr_out_if.source     o_out
);

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || o_out.ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign i_in.ready  = w_rdy1;
    assign o_out.valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: operand adjustment ----------------
    wpr_pkg::t_opnd  w_adj_a, w_adj_b;
    wpr_pkg::t_flags w_flags0;
    wpr_pkg::t_opnd  r_a1, r_b1;
    wpr_pkg::t_flags r_f1;

    wpr_prep u_prep (
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .i_op    (i_in.operation),
        .o_a     (w_adj_a),
        .o_b     (w_adj_b),
        .o_flags (w_flags0)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_a1 <= w_adj_a;
            r_b1 <= w_adj_b;
            r_f1 <= w_flags0;
        end
    end

    // ---------------- stage 2: rows and first adder level ----------------
    wpr_pkg::t_row w_rows [0:31];
    wpr_pkg::t_row w_s1   [0:19];
    wpr_pkg::t_row r_s1   [0:19];
    wpr_pkg::t_row r_row30, r_row31;
    wpr_pkg::t_flags r_f2;

    genvar gi;
    generate
        for (gi = 0; gi < wpr_pkg::XLEN; gi++) begin : g_rows
            // operand shifted by its bit place, sign fill above it
            assign w_rows[gi] = ({{wpr_pkg::XLEN{r_f1.fill}}, r_a1} << gi)
                                & {wpr_pkg::PLEN{r_b1[gi]}};
        end
        for (gi = 0; gi < 10; gi++) begin : g_lvl1
            wpr_csa3 u_csa (
                .i_x (w_rows[3*gi]),
                .i_y (w_rows[3*gi+1]),
                .i_z (w_rows[3*gi+2]),
                .o_s (w_s1[2*gi]),
                .o_c (w_s1[2*gi+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s1    <= w_s1;
            r_row30 <= w_rows[30];
            r_row31 <= w_rows[31];
            r_f2    <= r_f1;
        end
    end

    // ---------------- stage 3: adder levels two and three ----------------
    wpr_pkg::t_row w_s2 [0:13];
    wpr_pkg::t_row w_s3 [0:9];
    wpr_pkg::t_row r_s3 [0:9];
    wpr_pkg::t_flags r_f3;

    generate
        for (gi = 0; gi < 6; gi++) begin : g_lvl2
            wpr_csa3 u_csa (
                .i_x (r_s1[3*gi]),
                .i_y (r_s1[3*gi+1]),
                .i_z (r_s1[3*gi+2]),
                .o_s (w_s2[2*gi]),
                .o_c (w_s2[2*gi+1])
            );
        end
        for (gi = 0; gi < 4; gi++) begin : g_lvl3
            wpr_csa3 u_csa (
                .i_x (w_s2[3*gi]),
                .i_y (w_s2[3*gi+1]),
                .i_z (w_s2[3*gi+2]),
                .o_s (w_s3[2*gi]),
                .o_c (w_s3[2*gi+1])
            );
        end
    endgenerate

    // last pair of level one picks up row thirty
    wpr_csa3 u_csa_l2_tail (
        .i_x (r_s1[18]),
        .i_y (r_s1[19]),
        .i_z (r_row30),
        .o_s (w_s2[12]),
        .o_c (w_s2[13])
    );

    // and row thirty-one joins one level later
    wpr_csa3 u_csa_l3_tail (
        .i_x (w_s2[12]),
        .i_y (w_s2[13]),
        .i_z (r_row31),
        .o_s (w_s3[8]),
        .o_c (w_s3[9])
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3 <= w_s3;
            r_f3 <= r_f2;
        end
    end

    // ---------------- stage 4: adder levels four and five ----------------
    wpr_pkg::t_row w_s4 [0:5];
    wpr_pkg::t_row w_s5 [0:3];

    generate
        for (gi = 0; gi < 3; gi++) begin : g_lvl4
            wpr_csa3 u_csa (
                .i_x (r_s3[3*gi]),
                .i_y (r_s3[3*gi+1]),
                .i_z (r_s3[3*gi+2]),
                .o_s (w_s4[2*gi]),
                .o_c (w_s4[2*gi+1])
            );
        end
        for (gi = 0; gi < 2; gi++) begin : g_lvl5
            wpr_csa3 u_csa (
                .i_x (w_s4[3*gi]),
                .i_y (w_s4[3*gi+1]),
                .i_z (w_s4[3*gi+2]),
                .o_s (w_s5[2*gi]),
                .o_c (w_s5[2*gi+1])
            );
        end
    endgenerate

    // output register
    wpr_pkg::t_row r_sum_a, r_carry_a, r_sum_b, r_carry_b, r_leftover;
    logic          r_hi_sel, r_neg;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_sum_a    <= w_s5[0];
            r_carry_a  <= w_s5[1];
            r_sum_b    <= w_s5[2];
            r_carry_b  <= w_s5[3];
            // level three carry skips the last two levels
            r_leftover <= r_s3[9];
            r_hi_sel   <= r_f3.hi_sel;
            r_neg      <= r_f3.neg;
        end
    end

    assign o_out.row_sum_a        = r_sum_a;
    assign o_out.row_carry_a      = r_carry_a;
    assign o_out.row_sum_b        = r_sum_b;
    assign o_out.row_carry_b      = r_carry_b;
    assign o_out.row_leftover     = r_leftover;
    assign o_out.high_half_select = r_hi_sel;
    assign o_out.result_negative  = r_neg;

endmodule

>>> test/wallace_partial_product_reducer_test.sv
// ----------------------------------------------------------------------------
// wallace_partial_product_reducer_test
// self-checking bench for the carry-save partial product reducer
// ----------------------------------------------------------------------------
// Words of two operands and an operation code go in through the input
// channel. For every accepted word a predictor builds the 32 partial product
// rows, runs the same carry-save tree, and queues the five rows and two flags
// it expects. Each result word from the output channel is checked field by
// field against the oldest entry in that queue. A directed set covers the
// operand extremes, every operation code, and the negation and sign-fill
// cases. Random words follow in three idle phases. In the last phase the
// receiver holds off for a long stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module wallace_partial_product_reducer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_WORDS   = 510;     // per phase
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES   = 16;      // pipeline is four stages deep
    localparam int CYCLE_LIMIT    = 200000;
    localparam int NUM_PHASES     = 3;

    // one request word
    typedef struct packed {
        wpr_pkg::t_opnd a;
        wpr_pkg::t_opnd b;
        wpr_pkg::t_op   op;
    } t_mul_req;

    // rows and flags expected from the reducer
    typedef struct packed {
        wpr_pkg::t_row sum_a;
        wpr_pkg::t_row carry_a;
        wpr_pkg::t_row sum_b;
        wpr_pkg::t_row carry_b;
        wpr_pkg::t_row leftover;
        logic          hi_sel;
        logic          neg;
    } t_reduced;

    typedef struct packed {
        wpr_pkg::t_row s;
        wpr_pkg::t_row c;
    } t_csa_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wpr_in_if  in_if ();
    wpr_out_if out_if ();

    wallace_partial_product_reducer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_mul_req pending_reqs[$];      // words waiting to be offered
    t_reduced expected_rows[$];     // predictions waiting for their result
    t_mul_req drive_req;
    t_reduced got_rows;
    t_reduced want_rows;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase         = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    int cycle_count   = 0;
    int error_count   = 0;
    int words_in      = 0;
    int words_out     = 0;
    int negated_pairs = 0;
    int op_seen[4]    = '{0, 0, 0, 0};

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // one 3:2 carry-save adder, carry out of the top bit is dropped
    function automatic t_csa_out csa3(wpr_pkg::t_row x, wpr_pkg::t_row y, wpr_pkg::t_row z);
        t_csa_out r;
        r.s = x ^ y ^ z;
        r.c = ((x & y) | ((x ^ y) & z)) << 1;
        return r;
    endfunction

    function automatic t_reduced reduce_partial_products(wpr_pkg::t_opnd a,
                                                         wpr_pkg::t_opnd b,
                                                         wpr_pkg::t_op   op);
        wpr_pkg::t_row rows[32];
        wpr_pkg::t_row lvl1[20];
        wpr_pkg::t_row lvl2[14];
        wpr_pkg::t_row lvl3[10];
        wpr_pkg::t_row lvl4[6];
        wpr_pkg::t_row lvl5[4];
        t_csa_out      pair;
        t_reduced      r;
        logic          fill_mode;
        int            i;

        fill_mode = (op != wpr_pkg::OP_UNSIGNED);
        r.hi_sel  = (op != wpr_pkg::OP_NEG_LO);

        // both operands negative under the negating codes: make them
        // positive and carry on as unsigned
        if ((op == wpr_pkg::OP_NEG_LO || op == wpr_pkg::OP_NEG_HI) &&
            a[wpr_pkg::XLEN-1] && b[wpr_pkg::XLEN-1]) begin
            a = -a;
            b = -b;
            fill_mode = 1'b0;
        end
        r.neg = fill_mode && (a[wpr_pkg::XLEN-1] != b[wpr_pkg::XLEN-1]);

        // only a negative first operand sign-fills a row
        for (i = 0; i < 32; i++) begin
            rows[i] = '0;
            if (b[i]) begin
                rows[i] = wpr_pkg::t_row'(a) << i;
                if (fill_mode && a[wpr_pkg::XLEN-1])
                    rows[i] = rows[i] | ({wpr_pkg::PLEN{1'b1}} << (i + 32));
            end
        end

        for (i = 0; i < 10; i++) begin
            pair = csa3(rows[3*i], rows[3*i+1], rows[3*i+2]);
            lvl1[2*i]   = pair.s;
            lvl1[2*i+1] = pair.c;
        end

        for (i = 0; i < 6; i++) begin
            pair = csa3(lvl1[3*i], lvl1[3*i+1], lvl1[3*i+2]);
            lvl2[2*i]   = pair.s;
            lvl2[2*i+1] = pair.c;
        end
        pair = csa3(lvl1[18], lvl1[19], rows[30]);
        lvl2[12] = pair.s;
        lvl2[13] = pair.c;

        for (i = 0; i < 4; i++) begin
            pair = csa3(lvl2[3*i], lvl2[3*i+1], lvl2[3*i+2]);
            lvl3[2*i]   = pair.s;
            lvl3[2*i+1] = pair.c;
        end
        pair = csa3(lvl2[12], lvl2[13], rows[31]);
        lvl3[8] = pair.s;
        lvl3[9] = pair.c;

        for (i = 0; i < 3; i++) begin
            pair = csa3(lvl3[3*i], lvl3[3*i+1], lvl3[3*i+2]);
            lvl4[2*i]   = pair.s;
            lvl4[2*i+1] = pair.c;
        end

        for (i = 0; i < 2; i++) begin
            pair = csa3(lvl4[3*i], lvl4[3*i+1], lvl4[3*i+2]);
            lvl5[2*i]   = pair.s;
            lvl5[2*i+1] = pair.c;
        end

        r.sum_a    = lvl5[0];
        r.carry_a  = lvl5[1];
        r.sum_b    = lvl5[2];
        r.carry_b  = lvl5[3];
        r.leftover = lvl3[9];   // third-level carry goes out unreduced
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_request(wpr_pkg::t_opnd a, wpr_pkg::t_opnd b, wpr_pkg::t_op op);
        t_mul_req req;
        req.a  = a;
        req.b  = b;
        req.op = op;
        pending_reqs.push_back(req);
    endtask

    // mix of full random, sparse, small and extreme values
    function automatic wpr_pkg::t_opnd rand_operand();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            5:       return wpr_pkg::t_opnd'(1) << $urandom_range(wpr_pkg::XLEN - 1);
            6:       return -wpr_pkg::t_opnd'($urandom_range(255));
            7:       return wpr_pkg::t_opnd'($urandom_range(255));
            8:       return {1'b1, 31'($urandom)};
            9: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, {(wpr_pkg::XLEN-1){1'b0}}};
                    3:       return {1'b0, {(wpr_pkg::XLEN-1){1'b1}}};
                    default: return wpr_pkg::t_opnd'(1);
                endcase
            end
            default: return wpr_pkg::t_opnd'($urandom);
        endcase
    endfunction

    task automatic queue_random_words(int count);
        wpr_pkg::t_opnd a;
        wpr_pkg::t_opnd b;
        int             n;
        for (n = 0; n < count; n++) begin
            a = rand_operand();
            b = rand_operand();
            // a quarter of the words are forced to carry two negative operands so that
            // the negation path is well exercised
            if ($urandom_range(3) == 0) begin
                a[wpr_pkg::XLEN-1] = 1'b1;
                b[wpr_pkg::XLEN-1] = 1'b1;
            end
            queue_request(a, b, wpr_pkg::t_op'($urandom_range(3)));
        end
    endtask

    // reports one field, returns one on a mismatch
    function automatic int diff_field(string name, wpr_pkg::t_row want, wpr_pkg::t_row got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers pending words, holds a word until it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.operand_a <= '0;
            in_if.operand_b <= '0;
            in_if.operation <= wpr_pkg::OP_UNSIGNED;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_req = pending_reqs.pop_front();
                in_if.valid     <= 1'b1;
                in_if.operand_a <= drive_req.a;
                in_if.operand_b <= drive_req.b;
                in_if.operation <= drive_req.op;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, plus one long hold-off in the last
    // phase while the sender keeps offering words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (phase == NUM_PHASES - 1 && !hold_done) begin
            out_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input acceptance, checks on output acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                expected_rows.push_back(reduce_partial_products(
                    in_if.operand_a, in_if.operand_b, in_if.operation));
                words_in++;
                op_seen[in_if.operation]++;
                if ((in_if.operation == wpr_pkg::OP_NEG_LO ||
                     in_if.operation == wpr_pkg::OP_NEG_HI) &&
                    in_if.operand_a[wpr_pkg::XLEN-1] && in_if.operand_b[wpr_pkg::XLEN-1])
                    negated_pairs++;
            end
            if (out_if.valid && out_if.ready) begin
                got_rows.sum_a    = out_if.row_sum_a;
                got_rows.carry_a  = out_if.row_carry_a;
                got_rows.sum_b    = out_if.row_sum_b;
                got_rows.carry_b  = out_if.row_carry_b;
                got_rows.leftover = out_if.row_leftover;
                got_rows.hi_sel   = out_if.high_half_select;
                got_rows.neg      = out_if.result_negative;
                if (expected_rows.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, got_rows);
                    error_count++;
                end else begin
                    want_rows = expected_rows.pop_front();
                    words_out++;
                    error_count += diff_field("row_sum_a", want_rows.sum_a, got_rows.sum_a);
                    error_count += diff_field("row_carry_a", want_rows.carry_a,
                                              got_rows.carry_a);
                    error_count += diff_field("row_sum_b", want_rows.sum_b, got_rows.sum_b);
                    error_count += diff_field("row_carry_b", want_rows.carry_b,
                                              got_rows.carry_b);
                    error_count += diff_field("row_leftover", want_rows.leftover,
                                              got_rows.leftover);
                    error_count += diff_field("high_half_select",
                                              wpr_pkg::t_row'(want_rows.hi_sel),
                                              wpr_pkg::t_row'(got_rows.hi_sel));
                    error_count += diff_field("result_negative",
                                              wpr_pkg::t_row'(want_rows.neg),
                                              wpr_pkg::t_row'(got_rows.neg));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding",
                     $time, expected_rows.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, directed words, three idle phases, drain
    // ------------------------------------------------------------------------
    initial begin
        // channel signals are set by the driver and receiver while in reset
        i_rst_n = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // operand extremes under every code
        for (int k = 0; k < 4; k++) begin
            queue_request('0, '0, wpr_pkg::t_op'(k));
            queue_request('1, '1, wpr_pkg::t_op'(k));
            queue_request(32'h8000_0000, 32'h8000_0000, wpr_pkg::t_op'(k));
            queue_request(32'h7fff_ffff, 32'h8000_0000, wpr_pkg::t_op'(k));
        end
        // negative first operand only: rows are sign-filled
        queue_request(32'hffff_ffff, 32'h7fff_ffff, wpr_pkg::OP_SIGNED);
        // negative second operand only: no fill, flag alone marks the sign
        queue_request(32'h0000_0005, 32'hffff_fffb, wpr_pkg::OP_NEG_HI);
        // code zero leaves a pair of negatives as they are
        queue_request(32'hffff_fffb, 32'hffff_fffd, wpr_pkg::OP_SIGNED);
        // the same pair negated under the low-half code
        queue_request(32'hffff_fffb, 32'hffff_fffd, wpr_pkg::OP_NEG_LO);
        // unsigned products of wide operands
        queue_request(32'h7fff_ffff, 32'h7fff_ffff, wpr_pkg::OP_UNSIGNED);
        queue_request(32'hffff_ffff, 32'h0000_0001, wpr_pkg::OP_UNSIGNED);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase = p;
            queue_random_words(RANDOM_WORDS);
            while (pending_reqs.size() != 0 || in_if.valid || expected_rows.size() != 0)
                @(negedge i_clk);
        end

        // let any stray word come out before the verdict
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d words in %0d idle phases, %0d results checked",
                 words_in, NUM_PHASES, words_out);
        $display("codes 0/1/2/3 seen %0d/%0d/%0d/%0d times, %0d negative pairs negated",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], negated_pairs);
        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
